@@ rtl/mbus_frame_splitter_assert.svh @@
// Assertion macros shared by the frame splitter modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef MBUS_FRAME_SPLITTER_ASSERT_SVH
`define MBUS_FRAME_SPLITTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MBFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MBFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mbfs_pkg.sv @@
// Types and constants for the M-Bus frame splitter.
// Used by mbfs_parser, mbfs_out_fifo and mbus_frame_splitter; no dependencies.
`default_nettype none

package mbfs_pkg;

  // Start bytes that select the frame type.
  localparam logic [7:0] BYTE_ACK   = 8'hE5;
  localparam logic [7:0] BYTE_SHORT = 8'h10;
  localparam logic [7:0] BYTE_LONG  = 8'h68;

  // Frame lengths: short frames are fixed, long frames add an overhead to the L field.
  localparam logic [8:0] SHORT_LEN     = 9'd5;
  localparam logic [8:0] LONG_OVERHEAD = 9'd6;

  // Reset value of the idle timeout register.
  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

  // Input word command codes.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Frame kind codes on the result channel.
  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_SHORT = 2'd1;
  localparam logic [1:0] KIND_LONG  = 2'd2;

  // Result queue geometry.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  // Parser state.
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_SHORT = 2'd1,
    MODE_LONG  = 2'd2,
    MODE_DROP  = 2'd3
  } mode_t;

  // One result word.
  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       first;
    logic       last;
    logic       abort;
  } res_t;

  // Up to two result words produced by one input word; slot 1 implies slot 0.
  typedef struct packed {
    logic vld0;
    logic vld1;
    res_t res0;
    res_t res1;
  } push_t;

endpackage

`default_nettype wire

@@ rtl/mbus_frame_splitter.sv @@
// Top level of the M-Bus frame splitter: input register, timeout register,
// parser and result queue. Depends on mbfs_pkg, mbfs_parser and mbfs_out_fifo.
`default_nettype none

// Each input word (a received byte or a 1 ms tick) is captured in an input
// register, parsed once the queue has room, and its results (none, one, or an
// abort followed by a byte) written to a four-entry result queue, which drives
// the out_ ports directly; a result reaches the out_ ports through the input
// register and then the queue. The block takes one word per cycle as long as
// the queue holds at most two results, so words with at most one result stream
// at full rate while out_ready is high; a word that yields an abort and a byte
// puts two result words on the output, one after the other.
// The idle timeout register is written through cfg_wr_en/cfg_wr_data and
// resets to 2000 ticks.
module mbus_frame_splitter #(
  parameter int unsigned IDLE_COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_cmd,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_chunk_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic [1:0]       out_frame_kind,
  output logic             out_frame_first,
  output logic             out_frame_last,
  output logic             out_abort,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);
  import mbfs_pkg::*;

  logic        in_vld_r, in_vld_nxt;
  logic        in_cmd_r;
  logic [7:0]  in_byte_r;
  logic        in_cend_r;
  logic [15:0] timeout_r;
  logic        room;
  logic        proc;
  logic        take;
  push_t       push;
  res_t        out_res;

  // The held word is parsed once the queue has room for two results.
  assign proc       = in_vld_r && room;
  assign in_ready   = !in_vld_r || room;
  assign take       = in_valid && in_ready;
  assign in_vld_nxt = take ? 1'b1 : (proc ? 1'b0 : in_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      timeout_r <= TIMEOUT_RESET;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
    end
  end

  // Input word payload.
  always_ff @(posedge clk) begin
    if (take) begin
      in_cmd_r  <= in_cmd;
      in_byte_r <= in_rx_byte;
      in_cend_r <= in_chunk_end;
    end
  end

  mbfs_parser #(
    .IDLE_COUNT_BITS(IDLE_COUNT_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (proc),
    .item_cmd  (in_cmd_r),
    .item_byte (in_byte_r),
    .item_cend (in_cend_r),
    .timeout   (timeout_r),
    .push      (push)
  );

  mbfs_out_fifo u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room    (room),
    .out_vld (out_valid),
    .out_rdy (out_ready),
    .out_res (out_res)
  );

  // Result word onto the output ports.
  assign out_byte        = out_res.data;
  assign out_frame_kind  = out_res.kind;
  assign out_frame_first = out_res.first;
  assign out_frame_last  = out_res.last;
  assign out_abort       = out_res.abort;

endmodule

`default_nettype wire

@@ rtl/mbfs_parser.sv @@
// Frame parser: holds the framing state and idle counter and turns one input
// word into up to two result words. Depends on mbfs_pkg and the assertion header.
`default_nettype none
`include "mbus_frame_splitter_assert.svh"

module mbfs_parser #(
  parameter int unsigned IDLE_COUNT_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          item_vld,
  input  wire logic          item_cmd,
  input  wire logic [7:0]    item_byte,
  input  wire logic          item_cend,
  input  wire logic [15:0]   timeout,
  output mbfs_pkg::push_t    push
);
  import mbfs_pkg::*;

  localparam int unsigned CMP_W = (IDLE_COUNT_BITS > 16) ? IDLE_COUNT_BITS : 16;

  mode_t                      mode_r, mode_nxt;
  logic [8:0]                 bytes_r, bytes_nxt;
  logic [8:0]                 len_r, len_nxt;
  logic [IDLE_COUNT_BITS-1:0] idle_cnt_r, idle_nxt;

  mode_t      mode_eff;
  logic [8:0] bytes_eff;
  logic [8:0] len_eff;
  logic [8:0] bt_inc;
  logic [8:0] len_new;
  logic [1:0] kind_eff;
  logic       abort_hit;
  logic       byte_vld;
  res_t       res_a;
  res_t       res_b;
  logic [CMP_W-1:0] idle_ext;
  logic [CMP_W-1:0] timeout_ext;

  assign idle_ext    = CMP_W'(idle_cnt_r);
  assign timeout_ext = CMP_W'(timeout);

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      bytes_r    <= '0;
      len_r      <= '0;
      idle_cnt_r <= '0;
    end else begin
      mode_r     <= mode_nxt;
      bytes_r    <= bytes_nxt;
      len_r      <= len_nxt;
      idle_cnt_r <= idle_nxt;
    end
  end

  // Next state and result words for the word in hand.
  always_comb begin
    mode_nxt  = mode_r;
    bytes_nxt = bytes_r;
    len_nxt   = len_r;
    idle_nxt  = idle_cnt_r;
    mode_eff  = mode_r;
    bytes_eff = bytes_r;
    len_eff   = len_r;
    bt_inc    = '0;
    len_new   = '0;
    kind_eff  = KIND_SHORT;
    abort_hit = 1'b0;
    byte_vld  = 1'b0;
    res_a     = '0;
    res_b     = '0;
    if (item_vld) begin
      if (item_cmd == CMD_TICK) begin
        // A tick only advances the saturating idle counter.
        if (idle_cnt_r != '1) begin
          idle_nxt = idle_cnt_r + IDLE_COUNT_BITS'(1);
        end
      end else begin
        idle_nxt = '0;
        // A pending frame that has been idle too long is discarded first.
        if ((mode_r == MODE_SHORT || mode_r == MODE_LONG) && idle_ext > timeout_ext) begin
          abort_hit   = 1'b1;
          res_a.kind  = (mode_r == MODE_SHORT) ? KIND_SHORT : KIND_LONG;
          res_a.abort = 1'b1;
          mode_eff    = MODE_IDLE;
          bytes_eff   = '0;
          len_eff     = '0;
        end
        mode_nxt  = mode_eff;
        bytes_nxt = bytes_eff;
        len_nxt   = len_eff;
        case (mode_eff)
          MODE_IDLE: begin
            // The start byte selects the frame type.
            res_b.data  = item_byte;
            res_b.first = 1'b1;
            if (item_byte == BYTE_ACK) begin
              byte_vld   = 1'b1;
              res_b.kind = KIND_ACK;
              res_b.last = 1'b1;
            end else if (item_byte == BYTE_SHORT) begin
              byte_vld   = 1'b1;
              res_b.kind = KIND_SHORT;
              mode_nxt   = MODE_SHORT;
              bytes_nxt  = 9'd1;
              len_nxt    = SHORT_LEN;
            end else if (item_byte == BYTE_LONG) begin
              byte_vld   = 1'b1;
              res_b.kind = KIND_LONG;
              mode_nxt   = MODE_LONG;
              bytes_nxt  = 9'd1;
              len_nxt    = '0;
            end else if (!item_cend) begin
              mode_nxt = MODE_DROP;
            end
          end
          MODE_SHORT, MODE_LONG: begin
            // Inside a frame; a long frame takes its length from its second byte.
            kind_eff = (mode_eff == MODE_SHORT) ? KIND_SHORT : KIND_LONG;
            bt_inc   = bytes_eff + 9'd1;
            if (mode_eff == MODE_LONG && bt_inc == 9'd2) begin
              len_new = {1'b0, item_byte} + LONG_OVERHEAD;
            end else begin
              len_new = len_eff;
            end
            byte_vld   = 1'b1;
            res_b.data = item_byte;
            res_b.kind = kind_eff;
            if (bt_inc >= len_new) begin
              res_b.last = 1'b1;
              mode_nxt   = MODE_IDLE;
              bytes_nxt  = '0;
              len_nxt    = '0;
            end else begin
              bytes_nxt = bt_inc;
              len_nxt   = len_new;
            end
          end
          MODE_DROP: begin
            // Discard until the end of the chunk.
            if (item_cend) begin
              mode_nxt = MODE_IDLE;
            end
          end
          default: begin
            mode_nxt = MODE_IDLE;
          end
        endcase
      end
    end
  end

  // Pack the results: an abort always takes the first slot.
  always_comb begin
    push.vld0 = abort_hit | byte_vld;
    push.vld1 = abort_hit & byte_vld;
    push.res0 = abort_hit ? res_a : res_b;
    push.res1 = res_b;
  end

  `MBFS_ASSERT_NOW(a_abort_needs_frame, push.vld0 && push.res0.abort,
    mode_r == MODE_SHORT || mode_r == MODE_LONG, "abort without a pending frame")
  `MBFS_ASSERT_NEXT(a_byte_clears_idle, item_vld && item_cmd == CMD_BYTE,
    idle_cnt_r == '0, "idle counter not cleared by a byte")
  `MBFS_ASSERT_NOW(a_drop_is_silent, item_vld && mode_r == MODE_DROP,
    !push.vld0, "result produced while dropping a chunk")

endmodule

`default_nettype wire

@@ rtl/mbfs_out_fifo.sv @@
// Result queue: takes up to two result words a cycle and hands out one.
// Depends on mbfs_pkg and the assertion header.
`default_nettype none
`include "mbus_frame_splitter_assert.svh"

module mbfs_out_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire mbfs_pkg::push_t push,
  output logic                 room,
  output logic                 out_vld,
  input  wire logic            out_rdy,
  output mbfs_pkg::res_t       out_res
);
  import mbfs_pkg::*;

  localparam logic [FIFO_AW:0] DEPTH_C = (FIFO_AW + 1)'(FIFO_DEPTH);

  res_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic               pop;
  logic [FIFO_AW:0]   n_push;

  // Two free entries are needed before the parser may run.
  assign room    = (count_r <= DEPTH_C - (FIFO_AW + 1)'(2));
  assign out_vld = (count_r != '0);
  assign out_res = mem_r[rd_ptr_r];
  assign pop     = out_vld && out_rdy;
  assign n_push  = (FIFO_AW + 1)'(push.vld0) + (FIFO_AW + 1)'(push.vld1);

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + n_push[FIFO_AW-1:0];
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    count_nxt  = count_r + n_push - (FIFO_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage: slot 0 at the write pointer, slot 1 just after it.
  always_ff @(posedge clk) begin
    if (push.vld0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.vld1) begin
      mem_r[wr_ptr_r + FIFO_AW'(1)] <= push.res1;
    end
  end

  `MBFS_ASSERT_NOW(a_slot_order, push.vld1, push.vld0, "second slot pushed without first")
  `MBFS_ASSERT_NOW(a_no_overflow, 1'b1, count_r <= DEPTH_C, "result queue overflow")
  `MBFS_ASSERT_NEXT(a_pop_counts, pop && !push.vld0,
    count_r == $past(count_r) - (FIFO_AW + 1)'(1), "occupancy lost a pop")

endmodule

`default_nettype wire
